### rtl/assert_macros.svh
// assertion macros used by the monitor top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

### rtl/wdr_pkg.sv
// shared constants and types of the drift and rebirth monitor
`timescale 1ns / 1ps
package wdr_pkg;
  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned WINDOW_MAX_DEF = 8;
  localparam int unsigned MIN_SAMPLES    = 4;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned DISS_W    = 17;
  localparam int unsigned TOKEN_W   = 16;
  localparam int unsigned BIRTH_W   = 32;
  localparam int unsigned DTHR_W    = 16;
  localparam int unsigned TENSION_W = 28;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 28;

  typedef logic [1:0] action_t;
  localparam action_t ACT_PUSH  = 2'd0;
  localparam action_t ACT_TICK  = 2'd1;
  localparam action_t ACT_CHECK = 2'd2;

  typedef logic [1:0] rebirth_t;
  localparam rebirth_t REB_NONE   = 2'd0;
  localparam rebirth_t REB_LIFE   = 2'd1;
  localparam rebirth_t REB_METRIC = 2'd2;

  typedef logic signed [1:0] dir_t;
  localparam dir_t DIR_FLAT = 2'sb00;
  localparam dir_t DIR_UP   = 2'sb01;
  localparam dir_t DIR_DOWN = 2'sb11;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MIN_TOKENS = 3'd0;
  localparam cfg_idx_t CFG_DRIFT_THR  = 3'd1;
  localparam cfg_idx_t CFG_DISS_THR   = 3'd2;
  localparam cfg_idx_t CFG_TENSION    = 3'd3;
  localparam cfg_idx_t CFG_LIFETIME   = 3'd4;

  localparam logic [TOKEN_W-1:0]   MIN_TOKENS_RST  = 16'd16;
  localparam logic [DTHR_W-1:0]    DRIFT_THR_RST   = 16'd4915;
  localparam logic [DISS_W-1:0]    DISS_THR_RST    = 17'd3277;
  localparam logic [TENSION_W-1:0] TENSION_THR_RST = 28'd163840;
  localparam logic [TOKEN_W-1:0]   LIFETIME_RST    = 16'd256;
  localparam logic [TOKEN_W-1:0]   TOKEN_MAX       = 16'hFFFF;

  // 20 * comb > 32768  <=>  comb >= 1639 (dead band of 0.05)
  localparam logic [RATE_W:0]     DIR_LIMIT  = 17'd1639;
  // 100 * d > 32768  <=>  d >= 328 (step band of 0.01)
  localparam logic [SAMPLE_W-1:0] STEP_LIMIT = 16'd328;
  // floor(x / 10) > t  <=>  x > 10 * t + 9
  localparam logic [PROD_W-1:0]   TENSION_ROUND = 32'd9;
endpackage

### rtl/wdr_item_if.sv
// input item channel
`timescale 1ns / 1ps
interface wdr_item_if import wdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [SAMPLE_W-1:0] arousal;
  logic [SAMPLE_W-1:0] coherence;

  modport source (output valid, output action, output arousal, output coherence, input ready);
  modport sink   (input valid, input action, input arousal, input coherence, output ready);
endinterface

### rtl/wdr_result_if.sv
// result item channel
`timescale 1ns / 1ps
interface wdr_result_if import wdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RATE_W-1:0]  drift_mag;
  logic signed [1:0]  drift_sign;
  logic [DISS_W-1:0]  dissonance;
  logic [1:0]         rebirth;
  logic [BIRTH_W-1:0] generation;

  modport source (output valid, output drift_mag, output drift_sign, output dissonance,
                  output rebirth, output generation, input ready);
  modport sink   (input valid, input drift_mag, input drift_sign, input dissonance,
                  input rebirth, input generation, output ready);
endinterface

### rtl/wdr_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
interface wdr_cfg_if import wdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wdr_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module wdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/wdr_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wdr_div #(
  parameter int unsigned DVD_W = 19,
  parameter int unsigned DVS_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work;   // dividend bits shift out, quotient bits shift in
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem, work[DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DVS_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[DVS_W-1:0];
        end
        work <= {work[DVD_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/windowed_drift_rebirth_monitor_unit.sv
// top level of the windowed drift and rebirth monitor
`timescale 1ns / 1ps
`include "assert_macros.svh"
// usage
//   item:   valid/ready channel, one transaction per action (push, tick, check)
//   result: valid/ready channel, exactly one result transaction per item
//   cfg:    valid/ready write channel, ready whenever out of reset, register index
//           plus data; write only while the block is idle
// timing
//   one item at a time; item.ready is high only while the sequencer is idle
//   with at least four samples stored the window walk reads the newest n samples, n the
//   window (up to WINDOW_MAX), and the six half-window and step divisions share
//   one bit-serial divider; the result is loaded after the divisions and the
//   combine and multiply steps, and the next item can follow once it is loaded
//   with fewer than four samples the walk and divisions are skipped
// reset
//   clears write pointer, fill and token counts, sets the birth count to one,
//   loads default register values; ring contents stay undefined until pushed
// stall
//   a finished result sits in the output register; the next item is taken
//   meanwhile, but its own result waits until the held one is taken
module windowed_drift_rebirth_monitor_unit import wdr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input logic         clk,
  input logic         rst,
  wdr_item_if.sink    item,
  wdr_result_if.source result,
  wdr_cfg_if.sink     cfg
);
  localparam int unsigned PTR_W    = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W   = $clog2(RING_DEPTH + 1);
  localparam int unsigned N_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned HALF_CNT = WINDOW_MAX - WINDOW_MAX / 2;
  localparam int unsigned SUM_W    = SAMPLE_W + $clog2(HALF_CNT);
  localparam int unsigned DVS_W    = $clog2(WINDOW_MAX);
  localparam int unsigned PAIR_W   = 2 * SAMPLE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_READ, S_DIV, S_COMB1, S_COMB2, S_MULT, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DV_FA, DV_SA, DV_FC, DV_SC, DV_AD, DV_CD
  } div_sel_t;

  // configuration registers
  logic [TOKEN_W-1:0]   min_tokens;
  logic [DTHR_W-1:0]    drift_thr;
  logic [DISS_W-1:0]    diss_thr;
  logic [TENSION_W-1:0] tension_thr;
  logic [TOKEN_W-1:0]   lifetime;

  // block state
  state_t              state;
  logic [PTR_W-1:0]    write_slot;
  logic [FILL_W-1:0]   fill_count;
  logic [TOKEN_W-1:0]  token_count;
  logic [BIRTH_W-1:0]  births;
  action_t             cur_action;

  // window walk
  logic [N_W-1:0]      n;
  logic [N_W-1:0]      half;
  logic [N_W-1:0]      rd_cnt;
  logic [PTR_W-1:0]    rd_ptr;
  logic [SUM_W-1:0]    fa, sa, fc, sc;
  logic [SAMPLE_W-1:0] old_a, old_c, new_a, new_c;

  // division results
  div_sel_t            div_sel;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [SUM_W-1:0]    div_quot;
  logic [SUM_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic [SAMPLE_W-1:0] qa0, qa1, qc0, qc1, qad, qcd;

  // metrics
  logic signed [17:0]  comb_sum;
  logic [RATE_W-1:0]   rate;
  dir_t                dir;
  logic [DISS_W-1:0]   diss;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   tension_limit;

  // output register
  logic                res_valid;
  logic [RATE_W-1:0]   res_rate;
  dir_t                res_dir;
  logic [DISS_W-1:0]   res_diss;
  rebirth_t            res_reb;
  logic [BIRTH_W-1:0]  res_births;

  // combinational helpers
  logic                item_fire;
  logic                emit_fire;
  logic                ram_we;
  logic [PAIR_W-1:0]   ram_rdata;
  logic [SAMPLE_W-1:0] rd_a, rd_c;
  logic [N_W-1:0]      rd_idx;
  logic [N_W-1:0]      n_calc;
  logic [PTR_W:0]      start_ptr;
  logic                step_a_neg, step_c_neg;
  logic [SAMPLE_W-1:0] step_a_mag, step_c_mag;
  logic [17:0]         sum_mag;
  logic [RATE_W:0]     comb_mag;
  logic                opposite;
  rebirth_t            reb_code;

  assign item_fire = item.valid && item.ready;
  assign item.ready = (state == S_IDLE) && !rst;
  assign ram_we    = item_fire && (item.action == ACT_PUSH);
  assign emit_fire = (state == S_EMIT) && (!res_valid || result.ready);

  assign rd_a   = ram_rdata[PAIR_W-1:SAMPLE_W];
  assign rd_c   = ram_rdata[SAMPLE_W-1:0];
  assign rd_idx = rd_cnt - N_W'(1);

  // window size and oldest slot of the window
  assign n_calc = (fill_count >= FILL_W'(WINDOW_MAX)) ? N_W'(WINDOW_MAX)
                                                      : N_W'(fill_count);
  always_comb begin
    if ({1'b0, write_slot} >= (PTR_W + 1)'(n_calc)) begin
      start_ptr = {1'b0, write_slot} - (PTR_W + 1)'(n_calc);
    end else begin
      start_ptr = {1'b0, write_slot} + (PTR_W + 1)'(RING_DEPTH) - (PTR_W + 1)'(n_calc);
    end
  end

  // step deltas newest minus oldest, as sign and magnitude
  assign step_a_neg = new_a < old_a;
  assign step_c_neg = new_c < old_c;
  assign step_a_mag = step_a_neg ? old_a - new_a : new_a - old_a;
  assign step_c_mag = step_c_neg ? old_c - new_c : new_c - old_c;

  // operand select for the shared divider
  always_comb begin
    case (div_sel)
      DV_FA: begin
        div_dvd = fa;
        div_dvs = DVS_W'(half);
      end
      DV_SA: begin
        div_dvd = sa;
        div_dvs = DVS_W'(n - half);
      end
      DV_FC: begin
        div_dvd = fc;
        div_dvs = DVS_W'(half);
      end
      DV_SC: begin
        div_dvd = sc;
        div_dvs = DVS_W'(n - half);
      end
      DV_AD: begin
        div_dvd = SUM_W'(step_a_mag);
        div_dvs = DVS_W'(n - N_W'(1));
      end
      DV_CD: begin
        div_dvd = SUM_W'(step_c_mag);
        div_dvs = DVS_W'(n - N_W'(1));
      end
      default: begin
        div_dvd = fa;
        div_dvs = DVS_W'(half);
      end
    endcase
  end

  // combined drift: truncate toward zero, then magnitude
  assign sum_mag  = comb_sum[17] ? 18'(-comb_sum) : 18'(comb_sum);
  assign comb_mag = sum_mag[17:1];
  // opposite step directions beyond the band
  assign opposite = (qad >= STEP_LIMIT) && (qcd >= STEP_LIMIT) && (step_a_neg != step_c_neg);

  // rebirth decision from the finished metrics
  always_comb begin
    reb_code = REB_NONE;
    if (cur_action == ACT_CHECK && token_count >= min_tokens) begin
      if (rate > drift_thr || diss > diss_thr || prod > tension_limit) begin
        reb_code = REB_METRIC;
      end else if (token_count >= lifetime) begin
        reb_code = REB_LIFE;
      end
    end
  end

  wdr_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata ({item.arousal, item.coherence}),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  wdr_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // configuration writes
  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_tokens  <= MIN_TOKENS_RST;
      drift_thr   <= DRIFT_THR_RST;
      diss_thr    <= DISS_THR_RST;
      tension_thr <= TENSION_THR_RST;
      lifetime    <= LIFETIME_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_TOKENS: min_tokens  <= cfg.data[TOKEN_W-1:0];
        CFG_DRIFT_THR:  drift_thr   <= cfg.data[DTHR_W-1:0];
        CFG_DISS_THR:   diss_thr    <= cfg.data[DISS_W-1:0];
        CFG_TENSION:    tension_thr <= cfg.data[TENSION_W-1:0];
        CFG_LIFETIME:   lifetime    <= cfg.data[TOKEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_slot  <= '0;
      fill_count  <= '0;
      token_count <= '0;
      births      <= BIRTH_W'(1);
      div_start   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      // kick the divider after the window walk and after each quotient but the last
      div_start <= ((state == S_READ) && (rd_cnt == n)) ||
                   ((state == S_DIV) && div_done && (div_sel != DV_CD));
      // a new result replaces a taken one in the same cycle
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_fire) begin
            cur_action <= item.action;
            if (item.action == ACT_PUSH) begin
              write_slot <= (write_slot == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                   : write_slot + PTR_W'(1);
              if (fill_count != FILL_W'(RING_DEPTH)) begin
                fill_count <= fill_count + FILL_W'(1);
              end
            end else if (item.action == ACT_TICK) begin
              if (token_count != TOKEN_MAX) begin
                token_count <= token_count + TOKEN_W'(1);
              end
            end
            state <= S_START;
          end
        end

        S_START: begin
          if (fill_count < FILL_W'(MIN_SAMPLES)) begin
            // too few samples: all metrics zero
            rate  <= '0;
            dir   <= DIR_FLAT;
            diss  <= '0;
            state <= S_MULT;
          end else begin
            n      <= n_calc;
            half   <= n_calc >> 1;
            rd_ptr <= start_ptr[PTR_W-1:0];
            rd_cnt <= '0;
            fa     <= '0;
            sa     <= '0;
            fc     <= '0;
            sc     <= '0;
            state  <= S_READ;
          end
        end

        S_READ: begin
          // ram data returns in the cycle after its read address
          if (rd_cnt != n) begin
            rd_ptr <= (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
          end
          if (rd_cnt != '0) begin
            if (rd_idx < half) begin
              fa <= fa + SUM_W'(rd_a);
              fc <= fc + SUM_W'(rd_c);
            end else begin
              sa <= sa + SUM_W'(rd_a);
              sc <= sc + SUM_W'(rd_c);
            end
            if (rd_idx == '0) begin
              old_a <= rd_a;
              old_c <= rd_c;
            end
            if (rd_idx == n - N_W'(1)) begin
              new_a <= rd_a;
              new_c <= rd_c;
            end
          end
          rd_cnt <= rd_cnt + N_W'(1);
          if (rd_cnt == n) begin
            div_sel <= DV_FA;
            state   <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            case (div_sel)
              DV_FA: begin
                qa0     <= div_quot[SAMPLE_W-1:0];
                div_sel <= DV_SA;
              end
              DV_SA: begin
                qa1     <= div_quot[SAMPLE_W-1:0];
                div_sel <= DV_FC;
              end
              DV_FC: begin
                qc0     <= div_quot[SAMPLE_W-1:0];
                div_sel <= DV_SC;
              end
              DV_SC: begin
                qc1     <= div_quot[SAMPLE_W-1:0];
                div_sel <= DV_AD;
              end
              DV_AD: begin
                qad     <= div_quot[SAMPLE_W-1:0];
                div_sel <= DV_CD;
              end
              DV_CD: begin
                qcd   <= div_quot[SAMPLE_W-1:0];
                state <= S_COMB1;
              end
              default: state <= S_COMB1;
            endcase
          end
        end

        S_COMB1: begin
          // (later minus earlier) summed over both signals
          comb_sum <= $signed(18'({2'b00, qa1}) - 18'({2'b00, qa0})
                              + 18'({2'b00, qc1}) - 18'({2'b00, qc0}));
          diss     <= opposite ? DISS_W'({1'b0, qad} + {1'b0, qcd}) : '0;
          state    <= S_COMB2;
        end

        S_COMB2: begin
          rate <= comb_mag[RATE_W-1:0];
          if (comb_mag >= DIR_LIMIT) begin
            dir <= comb_sum[17] ? DIR_DOWN : DIR_UP;
          end else begin
            dir <= DIR_FLAT;
          end
          state <= S_MULT;
        end

        S_MULT: begin
          prod          <= PROD_W'(token_count) * PROD_W'(rate);
          tension_limit <= PROD_W'({tension_thr, 3'b000}) + PROD_W'({tension_thr, 1'b0})
                           + TENSION_ROUND;
          state         <= S_EMIT;
        end

        S_EMIT: begin
          if (emit_fire) begin
            res_rate  <= rate;
            res_dir   <= dir;
            res_diss  <= diss;
            res_reb   <= reb_code;
            if (reb_code != REB_NONE) begin
              token_count <= '0;
              births      <= births + BIRTH_W'(1);
              res_births  <= births + BIRTH_W'(1);
            end else begin
              res_births  <= births;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid      = res_valid;
  assign result.drift_mag  = res_rate;
  assign result.drift_sign = res_dir;
  assign result.dissonance = res_diss;
  assign result.rebirth    = res_reb;
  assign result.generation = res_births;

  // an accepted item always starts the sequencer
  `ASSERT_NEXT(a_accept_starts, clk, rst, item_fire, state == S_START)
  // the shared divider is never restarted while it is still working
  `ASSERT_IMPLIES(a_div_start_free, clk, rst, div_start, !div_busy)
  // a rebirth clears the token count
  `ASSERT_NEXT(a_rebirth_clears, clk, rst, emit_fire && reb_code != REB_NONE, token_count == '0)
  // a result is only loaded once the output register is free
  `ASSERT_IMPLIES(a_emit_free, clk, rst, emit_fire && res_valid, result.ready)
endmodule

### bench/wdr_rebirth_checker.sv
// predicts monitor results from observed channel traffic and compares them
`timescale 1ns / 1ps
module wdr_rebirth_checker import wdr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  wdr_item_if   item,
  wdr_result_if result,
  wdr_cfg_if    cfg,
  output int    fail_count,
  output int    pending,
  output int    compared,
  output int    life_births,
  output int    metric_births
);

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    dir_t               dir;
    logic [DISS_W-1:0]  diss;
    rebirth_t           reb;
    logic [BIRTH_W-1:0] births;
  } wdr_report_t;

  // register copies
  logic [TOKEN_W-1:0]   min_tokens;
  logic [DTHR_W-1:0]    drift_thr;
  logic [DISS_W-1:0]    diss_thr;
  logic [TENSION_W-1:0] tension_thr;
  logic [TOKEN_W-1:0]   lifetime;

  // monitor state
  logic [SAMPLE_W-1:0] a_ring [RING_DEPTH_DEF];
  logic [SAMPLE_W-1:0] c_ring [RING_DEPTH_DEF];
  int                  wr_slot;
  int                  fill;
  logic [TOKEN_W-1:0]  tokens;
  logic [BIRTH_W-1:0]  births;

  wdr_report_t expected_reports[$];

  function automatic int slot_back(int n, int i);
    return (wr_slot + RING_DEPTH_DEF - n + i) % RING_DEPTH_DEF;
  endfunction

  // drift, direction and dissonance over the newest window
  function automatic wdr_report_t measure_window();
    wdr_report_t r;
    int          n, half, idx;
    longint      early_a, late_a, early_c, late_c, va, vc;
    longint      da, dc, comb, step_a, step_c, gap;
    r = '0;
    if (fill < MIN_SAMPLES) return r;
    n = (fill < WINDOW_MAX_DEF) ? fill : WINDOW_MAX_DEF;
    half = n / 2;
    early_a = 0;
    late_a = 0;
    early_c = 0;
    late_c = 0;
    for (int i = 0; i < n; i++) begin
      idx = slot_back(n, i);
      va = a_ring[idx];
      vc = c_ring[idx];
      if (i < half) begin
        early_a += va;
        early_c += vc;
      end else begin
        late_a += va;
        late_c += vc;
      end
    end
    da = late_a / (n - half) - early_a / half;
    dc = late_c / (n - half) - early_c / half;
    comb = (da + dc) / 2;
    r.rate = RATE_W'(comb < 0 ? -comb : comb);
    if (comb * 20 > 32768) r.dir = DIR_UP;
    else if (comb * 20 < -32768) r.dir = DIR_DOWN;
    else r.dir = DIR_FLAT;
    va = a_ring[slot_back(n, n - 1)];
    vc = c_ring[slot_back(n, n - 1)];
    step_a = (va - longint'(a_ring[slot_back(n, 0)])) / (n - 1);
    step_c = (vc - longint'(c_ring[slot_back(n, 0)])) / (n - 1);
    // opposite moves beyond the step band
    if ((step_a * 100 > 32768 && step_c * 100 < -32768) ||
        (step_a * 100 < -32768 && step_c * 100 > 32768)) begin
      gap = step_a - step_c;
      r.diss = DISS_W'(gap < 0 ? -gap : gap);
    end
    return r;
  endfunction

  function automatic wdr_report_t advance_monitor(action_t act, logic [SAMPLE_W-1:0] a,
                                                  logic [SAMPLE_W-1:0] c);
    wdr_report_t r;
    longint      tension;
    longint      tok;
    case (act)
      ACT_PUSH: begin
        a_ring[wr_slot] = a;
        c_ring[wr_slot] = c;
        wr_slot = (wr_slot + 1) % RING_DEPTH_DEF;
        if (fill < RING_DEPTH_DEF) fill++;
      end
      ACT_TICK: begin
        if (tokens != TOKEN_MAX) tokens++;
      end
      default: ;
    endcase
    r = measure_window();
    r.reb = REB_NONE;
    if (act == ACT_CHECK && tokens >= min_tokens) begin
      tok = tokens;
      tension = (tok * r.rate) / 10;
      if (r.rate > drift_thr || r.diss > diss_thr || tension > tension_thr) r.reb = REB_METRIC;
      else if (tokens >= lifetime) r.reb = REB_LIFE;
      if (r.reb != REB_NONE) begin
        tokens = '0;
        births = births + 1'b1;
      end
    end
    r.births = births;
    return r;
  endfunction

  function automatic void latch_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
    case (idx)
      CFG_MIN_TOKENS: min_tokens  = value[TOKEN_W-1:0];
      CFG_DRIFT_THR:  drift_thr   = value[DTHR_W-1:0];
      CFG_DISS_THR:   diss_thr    = value[DISS_W-1:0];
      CFG_TENSION:    tension_thr = value[TENSION_W-1:0];
      CFG_LIFETIME:   lifetime    = value[TOKEN_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic compare_field(input string field, input logic signed [32:0] want,
                               input logic signed [32:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : observe
    wdr_report_t want;
    if (rst) begin
      min_tokens  = MIN_TOKENS_RST;
      drift_thr   = DRIFT_THR_RST;
      diss_thr    = DISS_THR_RST;
      tension_thr = TENSION_THR_RST;
      lifetime    = LIFETIME_RST;
      wr_slot = 0;
      fill = 0;
      tokens = '0;
      births = 32'd1;
      expected_reports.delete();
      fail_count = 0;
      compared = 0;
      life_births = 0;
      metric_births = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got drift_mag %0d",
                   $time, result.drift_mag);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          compared++;
          compare_field("drift_mag", want.rate, result.drift_mag);
          compare_field("drift_sign", want.dir, result.drift_sign);
          compare_field("dissonance", want.diss, result.dissonance);
          compare_field("rebirth", want.reb, result.rebirth);
          compare_field("generation", want.births, result.generation);
          if (want.reb == REB_LIFE) life_births++;
          if (want.reb == REB_METRIC) metric_births++;
        end
      end
      if (cfg.valid && cfg.ready) latch_register(cfg.index, cfg.data);
      if (item.valid && item.ready)
        expected_reports.push_back(advance_monitor(item.action, item.arousal, item.coherence));
    end
    pending = expected_reports.size();
  end

endmodule

### bench/tb_windowed_drift_rebirth_monitor_unit.sv
// stimulus, clock, reset and verdict for the drift and rebirth monitor
`timescale 1ns / 1ps
module tb_windowed_drift_rebirth_monitor_unit;
  import wdr_pkg::*;

  // action code the block must treat as a no-op
  localparam action_t ACT_UNUSED = 2'd3;

  // cycles without any transaction before giving up
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_HOLD    = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int TICK_BURST    = 40;

  logic clk = 1'b0;
  logic rst;

  // idling controls, percent of cycles
  int src_idle_pct;
  int dst_stall_pct;

  int fail_count, pending, compared, life_births, metric_births;
  int n_push, n_tick, n_check, n_unused, n_settings;
  int quiet_cycles;

  // random walk that shapes pushed samples into trends
  int a_lvl, c_lvl, a_slope, c_slope;

  wdr_item_if   item();
  wdr_result_if result();
  wdr_cfg_if    cfg();

  windowed_drift_rebirth_monitor_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  wdr_rebirth_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .result        (result),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .pending       (pending),
    .compared      (compared),
    .life_births   (life_births),
    .metric_births (metric_births)
  );

  always #5 clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    result.ready = ($urandom_range(99) >= dst_stall_pct);
  end

  // watchdog: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((item.valid && item.ready) || (result.valid && result.ready) ||
                 (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one item transaction; called and returns at a falling edge
  task automatic send_item(input action_t act, input logic [SAMPLE_W-1:0] a,
                           input logic [SAMPLE_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      item.valid = 1'b0;
      @(negedge clk);
    end
    item.valid     = 1'b1;
    item.action    = act;
    item.arousal   = a;
    item.coherence = c;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    case (act)
      ACT_PUSH:  n_push++;
      ACT_TICK:  n_tick++;
      ACT_CHECK: n_check++;
      default:   n_unused++;
    endcase
    @(negedge clk);
    item.valid = 1'b0;
  endtask

  // block is idle once every predicted result has been taken
  task automatic settle_results();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_register(input cfg_idx_t idx, input int unsigned value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = CFG_DAT_W'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic program_settings(input int unsigned min_tok, input int unsigned drift_thr,
                                  input int unsigned diss_thr, input int unsigned tension,
                                  input int unsigned life);
    program_register(CFG_MIN_TOKENS, min_tok);
    program_register(CFG_DRIFT_THR, drift_thr);
    program_register(CFG_DISS_THR, diss_thr);
    program_register(CFG_TENSION, tension);
    program_register(CFG_LIFETIME, life);
    n_settings++;
  endtask

  function automatic int unsigned pick4(input int unsigned v0, input int unsigned v1,
                                        input int unsigned v2, input int unsigned v3);
    case ($urandom_range(3))
      0: return v0;
      1: return v1;
      2: return v2;
      default: return v3;
    endcase
  endfunction

  function automatic int clamp_q15(input int v);
    if (v < 0) return 0;
    if (v > 32768) return 32768;
    return v;
  endfunction

  // trending sample pair, with occasional extremes and out-of-range values
  task automatic draw_sample_pair(output logic [SAMPLE_W-1:0] a, output logic [SAMPLE_W-1:0] c);
    int roll;
    if ($urandom_range(9) == 0) begin
      a_slope = int'($urandom_range(8000)) - 4000;
      c_slope = int'($urandom_range(8000)) - 4000;
    end
    a_lvl = clamp_q15(a_lvl + a_slope + int'($urandom_range(1000)) - 500);
    c_lvl = clamp_q15(c_lvl + c_slope + int'($urandom_range(1000)) - 500);
    roll = $urandom_range(99);
    if (roll < 4) begin
      a = SAMPLE_W'($urandom_range(65535));
      c = SAMPLE_W'($urandom_range(65535));
    end else if (roll < 8) begin
      a = SAMPLE_W'(32768 * $urandom_range(1));
      c = SAMPLE_W'(32768 * $urandom_range(1));
    end else begin
      a = SAMPLE_W'(a_lvl);
      c = SAMPLE_W'(c_lvl);
    end
  endtask

  // mostly pushes and ticks with regular checks; a few no-op codes as noise
  task automatic send_random_item();
    int                  pick;
    logic [SAMPLE_W-1:0] a, c;
    pick = $urandom_range(99);
    a = SAMPLE_W'($urandom_range(65535));
    c = SAMPLE_W'($urandom_range(65535));
    if (pick < 40) begin
      draw_sample_pair(a, c);
      send_item(ACT_PUSH, a, c);
    end else if (pick < 72) begin
      send_item(ACT_TICK, a, c);
    end else if (pick < 95) begin
      send_item(ACT_CHECK, a, c);
    end else begin
      send_item(ACT_UNUSED, a, c);
    end
  endtask

  initial begin
    int phase;
    int k;
    rst            = 1'b1;
    item.valid     = 1'b0;
    item.action    = ACT_PUSH;
    item.arousal   = '0;
    item.coherence = '0;
    cfg.valid      = 1'b0;
    cfg.index      = CFG_MIN_TOKENS;
    cfg.data       = '0;
    src_idle_pct   = 0;
    dst_stall_pct  = 0;
    n_push = 0;
    n_tick = 0;
    n_check = 0;
    n_unused = 0;
    n_settings = 0;
    a_lvl = 16384;
    c_lvl = 16384;
    a_slope = 2000;
    c_slope = -2000;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, reset register values, no idling ---

    // empty ring: metrics stay zero, too few tokens to rebirth
    send_item(ACT_CHECK, 16'h0000, 16'h0000);
    // unused action code with all-ones payload changes nothing
    send_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
    // a run of ticks while the ring is empty (fast path)
    for (k = 0; k < TICK_BURST; k++) send_item(ACT_TICK, SAMPLE_W'(k), SAMPLE_W'(~k));
    settle_results();
    // token count exactly at the lifetime gives a lifetime rebirth
    program_register(CFG_LIFETIME, TICK_BURST);
    send_item(ACT_CHECK, 16'h5555, 16'hAAAA);

    // fewer than four samples report no metrics; the fourth opens the window
    // with arousal rising and coherence falling, i.e. dissonance
    send_item(ACT_PUSH, 16'd0, 16'd32768);
    send_item(ACT_PUSH, 16'd0, 16'd32768);
    send_item(ACT_PUSH, 16'd32768, 16'd0);
    send_item(ACT_PUSH, 16'd32768, 16'd0);
    // token count back at zero, below min_tokens
    send_item(ACT_CHECK, 16'h0000, 16'h0000);
    settle_results();
    // with no token floor the dissonance fires a metric rebirth
    program_register(CFG_MIN_TOKENS, 0);
    send_item(ACT_CHECK, 16'h0000, 16'h0000);

    // out-of-range samples are stored as given and push the drift past 1.0
    send_item(ACT_PUSH, 16'hFFFF, 16'hFFFF);
    send_item(ACT_PUSH, 16'hFFFF, 16'hFFFF);
    send_item(ACT_PUSH, 16'hFFFF, 16'hFFFF);
    send_item(ACT_PUSH, 16'hFFFF, 16'hFFFF);
    send_item(ACT_CHECK, 16'h0000, 16'h0000);

    // lifetime zero with unreachable metric limits: a flat window still rebirths
    settle_results();
    program_settings(0, 32768, 65536, 268435455, 0);
    for (k = 0; k < WINDOW_MAX_DEF; k++) send_item(ACT_PUSH, 16'd16384, 16'd16384);
    send_item(ACT_CHECK, 16'h0000, 16'h0000);

    // --- random part: one register setting and one idling mode per phase ---
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_results();
      case (phase)
        0: program_settings(0, 0, 0, 0, 1);
        1: program_settings(65535, 32768, 65536, 268435455, 65535);
        2: program_settings(MIN_TOKENS_RST, DRIFT_THR_RST, DISS_THR_RST, TENSION_THR_RST,
                            LIFETIME_RST);
        default: program_settings(pick4(0, 16, $urandom_range(40), 8),
                                  pick4(0, 4915, $urandom_range(32768), 32768),
                                  pick4(0, 3277, $urandom_range(65536), 1000),
                                  pick4(0, 163840, $urandom_range(1 << 20), 268435455),
                                  pick4(1, 256, $urandom_range(60, 1), 0));
      endcase
      case (phase % 4)
        0: begin
          src_idle_pct  = 0;
          dst_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 65;
          dst_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          dst_stall_pct = 65;
        end
        default: begin
          src_idle_pct  = 20;
          dst_stall_pct = 20;
        end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // sender holds off mid-phase until every result is back
        if (k == PHASE_ITEMS / 2) settle_results();
        send_random_item();
      end
    end

    settle_results();
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    repeat (DRAIN_HOLD) @(negedge clk);

    $display("covered %0d items: %0d push, %0d tick, %0d check, %0d unused code",
             n_push + n_tick + n_check + n_unused, n_push, n_tick, n_check, n_unused);
    $display("%0d results compared over %0d register settings, %0d lifetime, %0d metric rebirths",
             compared, n_settings, life_births, metric_births);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
